[rtl/tws_pkg.sv]
// Package for the trie word store: sizes, command codes, word and control types.
`default_nettype none

package tws_pkg;

    // Node table size and alphabet size
    localparam int NODES    = 1024;
    localparam int ALPHABET = 26;

    // Derived widths
    localparam int IDX_W        = $clog2(NODES);
    localparam int USED_W       = $clog2(NODES + 1);
    localparam int SEL_W        = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
    localparam int ROW_W        = ALPHABET * IDX_W;
    localparam int LETTER_W     = 5;
    localparam int LETTER_CMP_W = 9;

    localparam logic [IDX_W-1:0] LAST_NODE = IDX_W'(NODES - 1);

    // Command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_SEARCH = 2'd1;
    localparam logic [1:0] CMD_PREFIX = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]          cmd;
        logic [LETTER_W-1:0] letter;
        logic                no_letter;
        logic                last;
    } in_word_t;

    typedef struct packed {
        logic found;
        logic status;
    } out_word_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic clear;
        logic look;
        logic mark;
        logic load;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_done;
        logic in_skip;
        logic in_walk;
        logic in_last;
        logic item_last;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

[rtl/tws_in_if.sv]
// Input word channel: valid, ready and one letter word.
`default_nettype none

interface tws_in_if import tws_pkg::*; ();
    logic     valid;
    logic     ready;
    in_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/tws_out_if.sv]
// Result word channel: valid, ready and one found/status word.
`default_nettype none

interface tws_out_if import tws_pkg::*; ();
    logic      valid;
    logic      ready;
    out_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/tws_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module tws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/tws_ctrl.sv]
// Controller state machine of the trie word store.
`default_nettype none

module tws_ctrl import tws_pkg::*; (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire dp_stat_t  stat,
    output ctrl_cmd_t      cmd
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_LOOK  = 3'd2;
    localparam logic [2:0] ST_MARK  = 3'd3;
    localparam logic [2:0] ST_REPLY = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        cmd        = '0;
        in_ready   = (state_reg == ST_IDLE);
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (stat.in_skip)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (stat.in_walk)
                    begin
                        state_next = ST_LOOK;
                    end
                    else if (stat.in_last)
                    begin
                        state_next = ST_MARK;
                    end
                end
            end
            ST_LOOK:
            begin
                cmd.look   = 1'b1;
                state_next = stat.item_last ? ST_MARK : ST_IDLE;
            end
            ST_MARK:
            begin
                cmd.mark   = 1'b1;
                state_next = ST_REPLY;
            end
            ST_REPLY:
            begin
                if (stat.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[rtl/tws_dp.sv]
// Datapath of the trie word store: walk registers, node memories, result register.
`default_nettype none

module tws_dp import tws_pkg::*; (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire in_word_t  in_data,
    input  wire ctrl_cmd_t cmd,
    output dp_stat_t       stat,
    input  wire logic      out_ready,
    output logic           out_valid,
    output out_word_t      out_data
);

    in_word_t           item_reg,         item_next;
    logic [IDX_W-1:0]   cur_node_reg,     cur_node_next;
    logic [USED_W-1:0]  nodes_used_reg,   nodes_used_next;
    logic               path_missing_reg, path_missing_next;
    logic               table_full_reg,   table_full_next;
    logic [IDX_W-1:0]   clr_addr_reg,     clr_addr_next;
    logic               out_valid_reg,    out_valid_next;
    out_word_t          out_data_reg,     out_data_next;

    logic [LETTER_CMP_W-1:0] in_letter_ext;
    logic [LETTER_CMP_W-1:0] item_letter_ext;
    logic                    in_range;
    logic                    in_steps;
    logic [SEL_W-1:0]        sel;
    logic [IDX_W-1:0]        slot;
    logic                    slot_hit;
    logic                    can_alloc;
    logic                    alloc;
    logic                    mark_set;
    logic [IDX_W-1:0]        new_idx;

    logic                    row_we;
    logic [IDX_W-1:0]        row_waddr;
    logic [ROW_W-1:0]        row_wdata;
    logic [ROW_W-1:0]        row_mod;
    logic [ROW_W-1:0]        row_rdata;
    logic                    end_we;
    logic                    end_wdata;
    logic                    end_rdata;

    // Decode the offered word
    assign in_letter_ext = LETTER_CMP_W'(in_data.letter);
    assign in_range      = in_letter_ext < LETTER_CMP_W'(ALPHABET);
    assign in_steps      = !in_data.no_letter && !path_missing_reg;

    assign stat.in_skip    = (in_data.cmd == CMD_UNUSED);
    assign stat.in_walk    = in_steps && in_range;
    assign stat.in_last    = in_data.last;
    assign stat.item_last  = item_reg.last;
    assign stat.clear_done = (clr_addr_reg == LAST_NODE);
    assign stat.out_free   = !out_valid_reg || out_ready;

    // Child slot of the held letter in the row just read
    assign item_letter_ext = LETTER_CMP_W'(item_reg.letter);
    assign sel             = item_letter_ext[SEL_W-1:0];
    assign slot            = row_rdata[sel*IDX_W +: IDX_W];
    assign slot_hit        = (slot != '0);
    assign can_alloc       = nodes_used_reg < USED_W'(NODES);
    assign new_idx         = nodes_used_reg[IDX_W-1:0];
    assign alloc           = cmd.look && !slot_hit && (item_reg.cmd == CMD_INSERT) && can_alloc;
    assign mark_set        = (item_reg.cmd == CMD_INSERT) && !table_full_reg && !path_missing_reg;

    always_comb
    begin
        row_mod = row_rdata;
        row_mod[sel*IDX_W +: IDX_W] = new_idx;
    end

    assign row_we    = cmd.clear || alloc;
    assign row_waddr = cmd.clear ? clr_addr_reg : cur_node_reg;
    assign row_wdata = cmd.clear ? '0 : row_mod;

    assign end_we    = cmd.clear || (cmd.mark && mark_set);
    assign end_wdata = !cmd.clear;

    tws_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NODES)
    ) u_child_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .re    (cmd.accept),
        .raddr (cur_node_reg),
        .rdata (row_rdata)
    );

    tws_ram #(
        .WIDTH (1),
        .DEPTH (NODES)
    ) u_end_ram (
        .clk   (clk),
        .we    (end_we),
        .waddr (row_waddr),
        .wdata (end_wdata),
        .re    (cmd.mark),
        .raddr (cur_node_reg),
        .rdata (end_rdata)
    );

    always_comb
    begin
        item_next         = item_reg;
        cur_node_next     = cur_node_reg;
        nodes_used_next   = nodes_used_reg;
        path_missing_next = path_missing_reg;
        table_full_next   = table_full_reg;
        clr_addr_next     = clr_addr_reg;
        out_valid_next    = out_valid_reg;
        out_data_next     = out_data_reg;

        if (cmd.clear)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
        end

        if (cmd.accept)
        begin
            item_next = in_data;
            if (!stat.in_skip && in_steps && !in_range)
            begin
                path_missing_next = 1'b1;
            end
        end

        if (cmd.look)
        begin
            if (slot_hit)
            begin
                cur_node_next = slot;
            end
            else if (item_reg.cmd == CMD_INSERT)
            begin
                if (can_alloc)
                begin
                    cur_node_next   = new_idx;
                    nodes_used_next = nodes_used_reg + 1'b1;
                end
                else
                begin
                    table_full_next   = 1'b1;
                    path_missing_next = 1'b1;
                end
            end
            else
            begin
                path_missing_next = 1'b1;
            end
        end

        if (cmd.load)
        begin
            unique case (item_reg.cmd)
                CMD_INSERT:
                begin
                    out_data_next.found  = !table_full_reg && !path_missing_reg;
                    out_data_next.status = table_full_reg;
                end
                CMD_SEARCH:
                begin
                    out_data_next.found  = !path_missing_reg && end_rdata;
                    out_data_next.status = 1'b0;
                end
                CMD_PREFIX:
                begin
                    out_data_next.found  = !path_missing_reg;
                    out_data_next.status = 1'b0;
                end
                default:
                begin
                    out_data_next = '0;
                end
            endcase
            cur_node_next     = '0;
            path_missing_next = 1'b0;
            table_full_next   = 1'b0;
            out_valid_next    = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_node_reg     <= '0;
            nodes_used_reg   <= USED_W'(1);
            path_missing_reg <= 1'b0;
            table_full_reg   <= 1'b0;
            clr_addr_reg     <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            cur_node_reg     <= cur_node_next;
            nodes_used_reg   <= nodes_used_next;
            path_missing_reg <= path_missing_next;
            table_full_reg   <= table_full_next;
            clr_addr_reg     <= clr_addr_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

[rtl/trie_word_store.sv]
// Top level of the trie word store: controller plus datapath.
//
//  channel | dir | word fields                        | handshake
//  --------+-----+------------------------------------+----------------------
//  req     | in  | cmd, letter, no_letter, last       | valid/ready, taken on both high
//  rsp     | out | found, status                      | valid/ready, taken on both high
//
// A letter that steps the walk has its node row read from the child memory
// (registered read) on acceptance; in LOOK the slot is then followed or a new
// node is written back into the same row. The final word of an entry then
// passes MARK (word-end memory access) and REPLY (result load, which waits
// while the result register is full), straight after acceptance if it has no
// step. A no-letter, non-final word or an unused command is done in IDLE. After
// reset a clearing pass over NODES (1024) rows zeroes both memories;
// req.ready stays low during it. The result sits in an output register, so a
// new word is accepted while rsp stalls; only a second result waits for it.
`default_nettype none

module trie_word_store import tws_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    tws_in_if.sink    req,
    tws_out_if.source rsp
);

    ctrl_cmd_t ctrl_cmd;
    dp_stat_t  dp_stat;
    logic      in_ready;
    logic      out_valid;
    out_word_t out_data;

    // Sequencer: clear pass, accept, look up slot, word-end access, reply
    tws_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .stat     (dp_stat),
        .cmd      (ctrl_cmd)
    );

    // Walk registers, node memories and the result register
    tws_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (req.data),
        .cmd       (ctrl_cmd),
        .stat      (dp_stat),
        .out_ready (rsp.ready),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    assign req.ready = in_ready;
    assign rsp.valid = out_valid;
    assign rsp.data  = out_data;

endmodule

`default_nettype wire

[rtl/tws_checker.sv]
// Port-level checks on the trie word store, bound to the top level.
`default_nettype none

module tws_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic req_ready,
    input wire logic rsp_valid,
    input wire logic rsp_ready,
    input wire logic rsp_found,
    input wire logic rsp_status
);

    // No words are taken in reset
    a_no_accept_in_reset: assert property (@(posedge clk) !rst_n |-> !req_ready)
        else $error("req ready during reset");

    // A full table never reports a stored word
    a_full_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp_status && rsp_found))
        else $error("status and found both set");

    // A new result is loaded only while the input side is held off
    a_load_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> !$past(req_ready))
        else $error("result appeared after a cycle with req ready");

    // Hold a stalled result
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found) && $stable(rsp_status))
        else $error("stalled result dropped or changed");

endmodule

bind trie_word_store tws_checker u_tws_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_found  (rsp.data.found),
    .rsp_status (rsp.data.status)
);

`default_nettype wire
